FILE: hdl/pkli_pkg.sv
package pkli_pkg;

	localparam int INDEX_W   = 6;
	localparam int COUNT_W   = 7;
	localparam int SEGMENT_W = 6;
	localparam int STATUS_W  = 2;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic REG_KNOT_COUNT = 1'b0;

	localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_SAT  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_ZERO = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_FEW  = 2'd3;

endpackage

FILE: hdl/path_knot_linear_interpolator.sv
// Path knot interpolator.
// Item channel (item_valid/item_ready): cmd selects a knot write (knot_index and the
// four knot values go into the table) or a query at query_distance.
// Result channel (result_valid/result_ready): one word per item carrying out_latitude,
// out_longitude, out_radius, segment and status; a knot write returns all zeros.
// knot_count is set over the APB port at byte address 0. The user must write it only
// while idle; the block does not enforce this. The block works on one item at a time:
// item_ready is high only while it is idle. A knot write goes from acceptance to
// ST_EMIT, which loads the result register. A query searches the knots in use,
// reading the single-port knot memory one knot at a time, and each of the three
// channels (W = VALUE_WIDTH) runs a W-step shift-add multiply and, unless the
// quotient overflows and saturates, a W-step restoring divide on one shared adder.
// Fewer than two knots go to ST_EMIT too; a zero-length segment ends after the fetch.
// The finished result sits in an output register; the block takes the next item
// while that word waits, and holds its next result until the receiver takes it.
// Reset clears knot_count and the handshake state; the knot table is not cleared and
// holds garbage until written.
module path_knot_linear_interpolator import pkli_pkg::*; #(
	parameter int MAX_KNOTS   = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [PADDR_W-1:0]            paddr,
	input  logic [PDATA_W-1:0]            pwdata,
	output logic [PDATA_W-1:0]            prdata,
	output logic                          pready,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  logic                          cmd,
	input  logic [INDEX_W-1:0]            knot_index,
	input  logic signed [VALUE_WIDTH-1:0] knot_distance,
	input  logic signed [VALUE_WIDTH-1:0] knot_latitude,
	input  logic signed [VALUE_WIDTH-1:0] knot_longitude,
	input  logic signed [VALUE_WIDTH-1:0] knot_radius,
	input  logic signed [VALUE_WIDTH-1:0] query_distance,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic signed [VALUE_WIDTH-1:0] out_latitude,
	output logic signed [VALUE_WIDTH-1:0] out_longitude,
	output logic signed [VALUE_WIDTH-1:0] out_radius,
	output logic [SEGMENT_W-1:0]          segment,
	output logic [STATUS_W-1:0]           status
);

	localparam int W    = VALUE_WIDTH;
	localparam int EW   = VALUE_WIDTH + 2;
	localparam int AW   = $clog2(MAX_KNOTS);
	localparam int NW   = $clog2(MAX_KNOTS + 1);
	localparam int CW   = (NW > COUNT_W) ? NW : COUNT_W;
	localparam int IW   = (NW > INDEX_W) ? NW : INDEX_W;
	localparam int BW   = $clog2(VALUE_WIDTH);
	localparam int RW   = 4 * VALUE_WIDTH;
	localparam int OFF_DIST = 0;
	localparam int OFF_LAT  = VALUE_WIDTH;
	localparam int OFF_LON  = 2 * VALUE_WIDTH;
	localparam int OFF_RAD  = 3 * VALUE_WIDTH;
	localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

	typedef enum logic [4:0] {
		ST_IDLE, ST_SRCH_RD, ST_SRCH_CMP, ST_FETCH0, ST_FETCH1, ST_FETCH2,
		ST_DS, ST_DX, ST_ABS_DS, ST_ABS_DX, ST_DY, ST_ABS_DY,
		ST_MUL, ST_CHK, ST_DIV, ST_RND, ST_FIN, ST_EMIT
	} state_t;

	typedef enum logic [1:0] {CH_LAT, CH_LON, CH_RAD} chan_t;

	function automatic logic [EW-1:0] sx(input logic [W-1:0] v);
		return {{2{v[W-1]}}, v};
	endfunction

	function automatic logic [EW-1:0] sx1(input logic [W:0] v);
		return {v[W], v};
	endfunction

	state_t state_q;
	chan_t  ch_q;

	logic [COUNT_W-1:0] knot_count_q;
	logic [RW-1:0]      knot_mem [MAX_KNOTS];
	logic [RW-1:0]      rd_q;
	logic [AW-1:0]      rd_addr;

	logic [W-1:0]  sp_q;
	logic [AW-1:0] last_q, idx_q, seg_q;
	logic [RW-1:0] row0_q, row1_q;
	logic [W:0]    ds_q, dx_q, dy_q;
	logic [W-1:0]  d_q, mx_q, m_q, hi_q, lo_q;
	logic [BW-1:0] cnt_q;
	logic          neg_q, round_q, sat_q;
	logic [W-1:0]  res_lat_q, res_lon_q, res_rad_q;
	logic [STATUS_W-1:0] res_status_q;

	logic [EW-1:0] alu_a, alu_b, alu_res;
	logic          alu_inv, alu_cin;
	logic [W-1:0]  y0, y1, fin_val, chan_val;
	logic          fin_fits, chan_done, chan_sat;

	logic          item_acc, cfg_wr, wr_ok, few;
	logic [CW-1:0] n_full;

	assign pready     = 1'b1;
	assign item_ready = (state_q == ST_IDLE);
	assign item_acc   = item_valid && item_ready;
	assign cfg_wr     = psel && penable && pwrite && pready && (paddr[2] == REG_KNOT_COUNT);
	assign prdata     = (paddr[2] == REG_KNOT_COUNT) ?
		{{(PDATA_W-COUNT_W){1'b0}}, knot_count_q} : '0;
	assign wr_ok      = IW'(knot_index) < IW'(MAX_KNOTS);
	assign n_full     = (CW'(knot_count_q) > CW'(MAX_KNOTS)) ? CW'(MAX_KNOTS) : CW'(knot_count_q);
	assign few        = n_full < CW'(2);

	assign alu_res = alu_a + (alu_inv ? ~alu_b : alu_b) + {{(EW-1){1'b0}}, alu_cin};

	always_comb begin
		unique case (ch_q)
			CH_LAT: begin
				y0 = row0_q[OFF_LAT +: W];
				y1 = row1_q[OFF_LAT +: W];
			end
			CH_LON: begin
				y0 = row0_q[OFF_LON +: W];
				y1 = row1_q[OFF_LON +: W];
			end
			default: begin
				y0 = row0_q[OFF_RAD +: W];
				y1 = row1_q[OFF_RAD +: W];
			end
		endcase
	end

	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_inv = 1'b0;
		alu_cin = 1'b0;
		unique case (state_q)
			ST_SRCH_CMP: begin
				alu_a = sx(sp_q);
				alu_b = sx(rd_q[OFF_DIST +: W]);
				alu_inv = 1'b1;
				alu_cin = 1'b1;
			end
			ST_DS: begin
				alu_a = sx(row1_q[OFF_DIST +: W]);
				alu_b = sx(row0_q[OFF_DIST +: W]);
				alu_inv = 1'b1;
				alu_cin = 1'b1;
			end
			ST_DX: begin
				alu_a = sx(sp_q);
				alu_b = sx(row0_q[OFF_DIST +: W]);
				alu_inv = 1'b1;
				alu_cin = 1'b1;
			end
			ST_ABS_DS: begin
				alu_a = ds_q[W] ? '0 : sx1(ds_q);
				alu_b = ds_q[W] ? sx1(ds_q) : '0;
				alu_inv = 1'b1;
				alu_cin = 1'b1;
			end
			ST_ABS_DX: begin
				alu_a = dx_q[W] ? '0 : sx1(dx_q);
				alu_b = dx_q[W] ? sx1(dx_q) : '0;
				alu_inv = 1'b1;
				alu_cin = 1'b1;
			end
			ST_DY: begin
				alu_a = sx(y1);
				alu_b = sx(y0);
				alu_inv = 1'b1;
				alu_cin = 1'b1;
			end
			ST_ABS_DY: begin
				alu_a = dy_q[W] ? '0 : sx1(dy_q);
				alu_b = dy_q[W] ? sx1(dy_q) : '0;
				alu_inv = 1'b1;
				alu_cin = 1'b1;
			end
			ST_MUL: begin
				alu_a = {2'b00, hi_q};
				alu_b = lo_q[0] ? {2'b00, m_q} : '0;
			end
			ST_CHK: begin
				alu_a = {2'b00, hi_q};
				alu_b = {2'b00, d_q};
				alu_inv = 1'b1;
				alu_cin = 1'b1;
			end
			ST_DIV: begin
				alu_a = {1'b0, hi_q, lo_q[W-1]};
				alu_b = {2'b00, d_q};
				alu_inv = 1'b1;
				alu_cin = 1'b1;
			end
			ST_RND: begin
				alu_a = {1'b0, hi_q, 1'b0};
				alu_b = {2'b00, d_q};
				alu_inv = 1'b1;
				alu_cin = 1'b1;
			end
			ST_FIN: begin
				alu_a = sx(y0);
				alu_b = {2'b00, lo_q};
				alu_inv = neg_q;
				alu_cin = neg_q ? !round_q : round_q;
			end
			default: begin
			end
		endcase
	end

	assign fin_fits = (alu_res[EW-1:W-1] == 3'b000) || (alu_res[EW-1:W-1] == 3'b111);
	assign fin_val  = fin_fits ? alu_res[W-1:0] : (alu_res[EW-1] ? MINV : MAXV);

	always_comb begin
		chan_done = 1'b0;
		chan_val  = fin_val;
		chan_sat  = 1'b0;
		if (state_q == ST_CHK && !alu_res[EW-1]) begin
			chan_done = 1'b1;
			chan_val  = neg_q ? MINV : MAXV;
			chan_sat  = 1'b1;
		end else if (state_q == ST_FIN) begin
			chan_done = 1'b1;
			chan_sat  = !fin_fits;
		end
	end

	always_comb begin
		priority if (state_q == ST_FETCH0) begin
			rd_addr = seg_q;
		end else if (state_q == ST_FETCH1) begin
			rd_addr = AW'(seg_q + 1'b1);
		end else begin
			rd_addr = idx_q;
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc && cmd == CMD_WRITE && wr_ok) begin
			knot_mem[AW'(knot_index)] <= {knot_radius, knot_longitude, knot_latitude,
				knot_distance};
		end
		rd_q <= knot_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			knot_count_q  <= '0;
			result_valid  <= 1'b0;
			out_latitude  <= '0;
			out_longitude <= '0;
			out_radius    <= '0;
			segment       <= '0;
			status        <= STATUS_OK;
		end else begin
			if (cfg_wr) begin
				knot_count_q <= pwdata[COUNT_W-1:0];
			end
			if (result_valid && result_ready && state_q != ST_EMIT) begin
				result_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item_acc) begin
						state_q <= (cmd == CMD_WRITE || few) ? ST_EMIT : ST_SRCH_RD;
					end
				end
				ST_SRCH_RD: state_q <= ST_SRCH_CMP;
				ST_SRCH_CMP: state_q <= (idx_q == last_q) ? ST_FETCH0 : ST_SRCH_RD;
				ST_FETCH0: state_q <= ST_FETCH1;
				ST_FETCH1: state_q <= ST_FETCH2;
				ST_FETCH2: state_q <= ST_DS;
				ST_DS: state_q <= (alu_res == '0) ? ST_EMIT : ST_DX;
				ST_DX: state_q <= ST_ABS_DS;
				ST_ABS_DS: state_q <= ST_ABS_DX;
				ST_ABS_DX: state_q <= ST_DY;
				ST_DY: state_q <= ST_ABS_DY;
				ST_ABS_DY: state_q <= ST_MUL;
				ST_MUL: state_q <= (cnt_q == '0) ? ST_CHK : ST_MUL;
				ST_CHK: begin
					if (chan_done) begin
						state_q <= (ch_q == CH_RAD) ? ST_EMIT : ST_DY;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: state_q <= (cnt_q == '0) ? ST_RND : ST_DIV;
				ST_RND: state_q <= ST_FIN;
				ST_FIN: state_q <= (ch_q == CH_RAD) ? ST_EMIT : ST_DY;
				ST_EMIT: begin
					if (!result_valid || result_ready) begin
						result_valid  <= 1'b1;
						out_latitude  <= res_lat_q;
						out_longitude <= res_lon_q;
						out_radius    <= res_rad_q;
						segment       <= SEGMENT_W'(seg_q);
						status        <= res_status_q;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			sp_q         <= query_distance;
			last_q       <= AW'(n_full - CW'(2));
			idx_q        <= '0;
			seg_q        <= '0;
			sat_q        <= 1'b0;
			ch_q         <= CH_LAT;
			res_lat_q    <= '0;
			res_lon_q    <= '0;
			res_rad_q    <= '0;
			res_status_q <= (cmd == CMD_QUERY && few) ? STATUS_FEW : STATUS_OK;
		end
		unique case (state_q)
			ST_SRCH_CMP: begin
				if (!alu_res[EW-1]) begin
					seg_q <= idx_q;
				end
				idx_q <= AW'(idx_q + 1'b1);
			end
			ST_FETCH1: row0_q <= rd_q;
			ST_FETCH2: row1_q <= rd_q;
			ST_DS: begin
				ds_q <= alu_res[W:0];
				if (alu_res == '0) begin
					res_lat_q    <= row0_q[OFF_LAT +: W];
					res_lon_q    <= row0_q[OFF_LON +: W];
					res_rad_q    <= row0_q[OFF_RAD +: W];
					res_status_q <= STATUS_ZERO;
				end
			end
			ST_DX: dx_q <= alu_res[W:0];
			ST_ABS_DS: d_q <= alu_res[W-1:0];
			ST_ABS_DX: mx_q <= alu_res[W-1:0];
			ST_DY: dy_q <= alu_res[W:0];
			ST_ABS_DY: begin
				m_q   <= alu_res[W-1:0];
				hi_q  <= '0;
				lo_q  <= mx_q;
				cnt_q <= BW'(W - 1);
				neg_q <= dy_q[W] ^ dx_q[W] ^ ds_q[W];
			end
			ST_MUL: begin
				hi_q  <= alu_res[W:1];
				lo_q  <= {alu_res[0], lo_q[W-1:1]};
				cnt_q <= cnt_q - 1'b1;
			end
			ST_CHK: cnt_q <= BW'(W - 1);
			ST_DIV: begin
				hi_q  <= alu_res[EW-1] ? {hi_q[W-2:0], lo_q[W-1]} : alu_res[W-1:0];
				lo_q  <= {lo_q[W-2:0], !alu_res[EW-1]};
				cnt_q <= cnt_q - 1'b1;
			end
			ST_RND: round_q <= !alu_res[EW-1];
			default: begin
			end
		endcase
		if (chan_done) begin
			unique case (ch_q)
				CH_LAT: begin
					res_lat_q <= chan_val;
					ch_q      <= CH_LON;
				end
				CH_LON: begin
					res_lon_q <= chan_val;
					ch_q      <= CH_RAD;
				end
				default: begin
					res_rad_q    <= chan_val;
					res_status_q <= (sat_q || chan_sat) ? STATUS_SAT : STATUS_OK;
				end
			endcase
			sat_q <= sat_q || chan_sat;
		end
	end

endmodule

FILE: hdl/pkli_checker.sv
module pkli_checker import pkli_pkg::*; #(
	parameter int VALUE_WIDTH = 32
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          item_valid,
	input logic                          item_ready,
	input logic                          result_valid,
	input logic                          result_ready,
	input logic signed [VALUE_WIDTH-1:0] out_latitude,
	input logic signed [VALUE_WIDTH-1:0] out_longitude,
	input logic signed [VALUE_WIDTH-1:0] out_radius,
	input logic [SEGMENT_W-1:0]          segment,
	input logic [STATUS_W-1:0]           status
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(out_latitude) &&
		$stable(out_longitude) && $stable(out_radius) && $stable(segment) && $stable(status))
		else $error("result word changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item taken while the previous one is still in work");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(!item_ready))
		else $error("result word appeared with no item in work");

	a_few_knots_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == STATUS_FEW |-> out_latitude == '0 &&
		out_longitude == '0 && out_radius == '0 && segment == '0)
		else $error("too-few-knots result carries nonzero fields");

endmodule

bind path_knot_linear_interpolator pkli_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_pkli_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.out_latitude (out_latitude),
	.out_longitude(out_longitude),
	.out_radius   (out_radius),
	.segment      (segment),
	.status       (status)
);
